@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

@@ rtl/hrmp_pkg.sv @@
// Package: types and constants of the heart rate measurement parser.
`default_nettype none

package hrmp_pkg;

  localparam int MAX_NOTIFY_BYTES_DEF = 32;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_RATE_CHANNEL     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL_CHANNEL = 8'd1;

  localparam logic [7:0] RATE_CHANNEL_RST     = 8'd22;
  localparam logic [7:0] INTERVAL_CHANNEL_RST = 8'd23;

  localparam logic [4:0] FLAG_WIDE_RATE     = 5'h01;
  localparam logic [4:0] FLAG_CONTACT_SEEN  = 5'h02;
  localparam logic [4:0] FLAG_CONTACT_SUPP  = 5'h04;
  localparam logic [4:0] FLAG_ENERGY        = 5'h08;
  localparam logic [4:0] FLAG_RR_PRESENT    = 5'h10;

  localparam logic [7:0] RATE_SAT = 8'd255;

  // rr ticks of 1/1024 s to us: rr * 1000000 / 1024 = rr * 15625 >> 4
  localparam int US_PER_SEC    = 1000000;
  localparam int TICKS_PER_SEC = 1024;
  localparam int RR_SHIFT      = 4;
  localparam int RR_MUL        = US_PER_SEC / (TICKS_PER_SEC >> RR_SHIFT);
  localparam int RR_PROD_W     = 30;

  localparam logic KIND_RATE     = 1'b0;
  localparam logic KIND_INTERVAL = 1'b1;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [62:0] arrival_time_us;
    logic        session_running;
  } in_item_t;

  typedef struct packed {
    logic        sample_valid;
    logic        sample_kind;
    logic [7:0]  channel_number;
    logic [63:0] sample_time_us;
    logic [15:0] sample_value;
    logic [7:0]  latest_rate;
    logic        contact_lost;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/heart_rate_measurement_parser_top.sv @@
// Top level: heart rate measurement notification parser.
`default_nettype none

// Usage:
//   Input channel in_valid/in_stall/in_data carries one notification byte per
//   request; first_byte marks the flags byte and latches arrival_time_us.
//   Output channel out_valid/out_stall/out_data gives exactly one result per
//   input byte; sample_valid tells whether it carries a rate or RR sample.
//   Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the
//   rate channel (index 0) and interval channel (index 1); cfg_ready is
//   always high, other indexes are dropped.
//   The result is registered; out_valid rises in the cycle after a byte is accepted.
//   Throughput: one byte per cycle unless a result is held under out_stall;
//   decode, the 16x14 RR scale multiply and the 64-bit time subtract sit
//   between the input port and the result register.
//   Reset: all parse state clears, channels return to 22 and 23, no result
//   is pending; bytes before the first flags byte are ignored.
//   Stall: while a result is held under out_stall, in_stall is raised and
//   no new byte is taken.
module heart_rate_measurement_parser_top #(
  parameter int MAX_NOTIFY_BYTES = hrmp_pkg::MAX_NOTIFY_BYTES_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  hrmp_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  wire                               out_stall,
  output hrmp_pkg::out_item_t               out_data,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [hrmp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire [hrmp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int POS_W = $clog2(MAX_NOTIFY_BYTES + 1);
  localparam logic [POS_W-1:0] POS_CAP = POS_W'(MAX_NOTIFY_BYTES);

  logic [7:0]       rate_channel;
  logic [7:0]       interval_channel;

  logic [4:0]       flag_bits,         flag_bits_next;
  logic [POS_W-1:0] byte_position,     byte_position_next;
  logic [7:0]       low_byte_hold,     low_byte_hold_next;
  logic [63:0]      interval_end_time, interval_end_time_next;
  logic             emit_enabled,      emit_enabled_next;
  logic [7:0]       rate_reg,          rate_reg_next;
  logic             contact_lost_reg,  contact_lost_reg_next;
  logic             frame_active,      frame_active_next;

  hrmp_pkg::out_item_t result;

  logic                         in_accept;
  logic [POS_W-1:0]             pos_eff;
  logic [2:0]                   hdr_last;
  logic [POS_W-1:0]             hdr_last_w;
  logic                         wide;
  logic [8:0]                   rate_raw;
  logic [15:0]                  rr;
  logic [hrmp_pkg::RR_PROD_W-1:0] rr_prod;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign wide       = (flag_bits & hrmp_pkg::FLAG_WIDE_RATE) != 5'd0;
  assign hdr_last   = (wide ? 3'd2 : 3'd1) +
                      (((flag_bits & hrmp_pkg::FLAG_ENERGY) != 5'd0) ? 3'd2 : 3'd0);
  assign hdr_last_w = POS_W'(hdr_last);
  assign rr         = {in_data.data_byte, low_byte_hold};
  assign rr_prod    = hrmp_pkg::RR_PROD_W'(rr) * hrmp_pkg::RR_PROD_W'(hrmp_pkg::RR_MUL);

  always_comb begin
    flag_bits_next         = flag_bits;
    byte_position_next     = byte_position;
    low_byte_hold_next     = low_byte_hold;
    interval_end_time_next = interval_end_time;
    emit_enabled_next      = emit_enabled;
    rate_reg_next          = rate_reg;
    contact_lost_reg_next  = contact_lost_reg;
    frame_active_next      = frame_active;
    pos_eff                = byte_position;
    rate_raw               = 9'd0;
    result                 = '0;

    if (in_data.first_byte) begin
      frame_active_next      = 1'b1;
      pos_eff                = '0;
      byte_position_next     = '0;
      interval_end_time_next = {1'b0, in_data.arrival_time_us};
      emit_enabled_next      = 1'b0;
      low_byte_hold_next     = 8'd0;
    end

    if (frame_active_next && pos_eff < POS_CAP) begin
      if (pos_eff == '0) begin
        flag_bits_next = in_data.data_byte[4:0];
      end else begin
        if (pos_eff <= (wide ? POS_W'(2) : POS_W'(1))) begin
          if (wide && pos_eff == POS_W'(1)) begin
            low_byte_hold_next = in_data.data_byte;
          end else begin
            if (wide) begin
              rate_raw = (in_data.data_byte != 8'd0) ? 9'h100 : {1'b0, low_byte_hold_next};
            end else begin
              rate_raw = {1'b0, in_data.data_byte};
            end
            rate_reg_next = rate_raw[8] ? hrmp_pkg::RATE_SAT : rate_raw[7:0];
            contact_lost_reg_next =
              ((flag_bits & hrmp_pkg::FLAG_CONTACT_SUPP) != 5'd0) &&
              ((flag_bits & hrmp_pkg::FLAG_CONTACT_SEEN) == 5'd0);
          end
        end
        if (pos_eff == hdr_last_w) begin
          emit_enabled_next = in_data.session_running;
          if (in_data.session_running) begin
            result.sample_valid   = 1'b1;
            result.sample_kind    = hrmp_pkg::KIND_RATE;
            result.channel_number = rate_channel;
            result.sample_time_us = interval_end_time_next;
            result.sample_value   = {8'd0, rate_reg_next};
          end
        end else if (pos_eff > hdr_last_w && emit_enabled_next &&
                     (flag_bits & hrmp_pkg::FLAG_RR_PRESENT) != 5'd0) begin
          if (pos_eff[0] ^ hdr_last[0]) begin
            low_byte_hold_next = in_data.data_byte;
          end else begin
            result.sample_valid    = 1'b1;
            result.sample_kind     = hrmp_pkg::KIND_INTERVAL;
            result.channel_number  = interval_channel;
            result.sample_time_us  = interval_end_time_next;
            result.sample_value    = rr;
            interval_end_time_next = interval_end_time_next -
              64'(rr_prod >> hrmp_pkg::RR_SHIFT);
          end
        end
      end
      byte_position_next = pos_eff + POS_W'(1);
    end

    result.latest_rate  = rate_reg_next;
    result.contact_lost = contact_lost_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_channel     <= hrmp_pkg::RATE_CHANNEL_RST;
      interval_channel <= hrmp_pkg::INTERVAL_CHANNEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hrmp_pkg::CFG_RATE_CHANNEL:     rate_channel     <= cfg_data;
        hrmp_pkg::CFG_INTERVAL_CHANNEL: interval_channel <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_bits         <= '0;
      byte_position     <= '0;
      low_byte_hold     <= '0;
      interval_end_time <= '0;
      emit_enabled      <= 1'b0;
      rate_reg          <= '0;
      contact_lost_reg  <= 1'b0;
      frame_active      <= 1'b0;
    end else if (in_accept) begin
      flag_bits         <= flag_bits_next;
      byte_position     <= byte_position_next;
      low_byte_hold     <= low_byte_hold_next;
      interval_end_time <= interval_end_time_next;
      emit_enabled      <= emit_enabled_next;
      rate_reg          <= rate_reg_next;
      contact_lost_reg  <= contact_lost_reg_next;
      frame_active      <= frame_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_accept || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

@@ rtl/hrmp_checker.sv @@
// Checker: port-level assertions for the heart rate measurement parser.
`default_nettype none

`include "assert_macros.svh"

module hrmp_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             in_valid,
  input wire                             in_stall,
  input wire                             out_valid,
  input wire                             out_stall,
  input hrmp_pkg::out_item_t             out_data
);

  logic empty_fields_zero;

  assign empty_fields_zero = out_data.sample_kind == hrmp_pkg::KIND_RATE &&
                             out_data.channel_number == 8'd0 &&
                             out_data.sample_time_us == 64'd0 &&
                             out_data.sample_value == 16'd0;

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `ASSERT_IMPLIES(a_in_stall_src, clk, rst, in_stall, out_valid && out_stall)
  `ASSERT_NEXT(a_accept_gives_result, clk, rst, in_valid && !in_stall, out_valid)
  `ASSERT_IMPLIES(a_empty_result, clk, rst, out_valid && !out_data.sample_valid, empty_fields_zero)

endmodule

bind heart_rate_measurement_parser_top hrmp_checker u_hrmp_checker (.*);

`default_nettype wire
